@@ rtl/sparse_row_product_accumulator_top_defines.svh @@
// Assertion macros for the sparse row product accumulator
`ifndef SPARSE_ROW_PRODUCT_ACCUMULATOR_TOP_DEFINES_SVH
`define SPARSE_ROW_PRODUCT_ACCUMULATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SRPA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRPA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define SRPA_ASSERT(label, clk, rst_n, prop, msg)
`define SRPA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

@@ rtl/srpa_pkg.sv @@
package srpa_pkg;

  localparam int MaxCols   = 64;
  localparam int BRows     = 256;
  localparam int BEntries  = 4096;
  localparam int ColW      = 6;
  localparam int SlotW     = 7;
  localparam int PtrW      = 13;
  localparam int AddrW     = 12;
  localparam int RowW      = 9;

  typedef enum logic [1:0] {
    OP_LOAD_START = 2'd0,
    OP_LOAD_ENTRY = 2'd1,
    OP_A_NONZERO  = 2'd2,
    OP_END_ROW    = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RS0,
    ST_RS1,
    ST_RS2,
    ST_RD,
    ST_MUL,
    ST_ACC_RD,
    ST_ACC,
    ST_EMIT_RD,
    ST_EMIT,
    ST_CLEAR
  } state_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                input logic signed [63:0] y);
    logic signed [63:0] r;
    r = x + y;
    if ((x[63] == y[63]) && (r[63] != x[63])) begin
      sat_add = x[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add = r;
    end
  endfunction

endpackage

@@ rtl/sparse_row_product_accumulator_top.sv @@
// Sparse row product accumulator, Gustavson row method, one item in flight at a time.
// An A nonzero reads the row bounds, then walks each B entry in turn (entry read, multiply,
// slot read, accumulate); a new column with all slots taken skips the accumulate.
// End of row: each slot in use is emitted as a result (a lone marker if none), each held
// until out_tready takes it, then the column map is cleared.
// rst_n synchronous, active low: map valid bits and slot count clear; B and sums undefined.
`include "sparse_row_product_accumulator_top_defines.svh"

module sparse_row_product_accumulator_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode[1:0], b_row[10:2], b_pointer[23:11], b_slot[35:24], b_column[41:36],
  // b_value[73:42], a_value[105:74], zero fill [111:106]
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_column[5:0], out_value[69:6], zero fill [71:70]
  output logic [71:0]  out_tdata,
  // entry_valid
  output logic         out_tuser,
  // row_last
  output logic         out_tlast
);

  // input fields
  logic [1:0]                         f_op;
  logic [srpa_pkg::RowW-1:0]          f_row;
  logic [srpa_pkg::PtrW-1:0]          f_ptr;
  logic [srpa_pkg::AddrW-1:0]         f_slot;
  logic [srpa_pkg::ColW-1:0]          f_col;
  logic signed [31:0]                 f_bval;
  logic signed [31:0]                 f_aval;
  assign f_op   = in_tdata[1:0];
  assign f_row  = in_tdata[10:2];
  assign f_ptr  = in_tdata[23:11];
  assign f_slot = in_tdata[35:24];
  assign f_col  = in_tdata[41:36];
  assign f_bval = in_tdata[73:42];
  assign f_aval = in_tdata[105:74];

  srpa_pkg::state_t state_r, state_nxt;

  // B memories
  logic [srpa_pkg::PtrW-1:0]  rs_mem [srpa_pkg::BRows+1];
  logic [srpa_pkg::ColW-1:0]  col_mem [srpa_pkg::BEntries];
  logic [31:0]                val_mem [srpa_pkg::BEntries];
  logic [srpa_pkg::PtrW-1:0]  rs_q;
  logic [srpa_pkg::ColW-1:0]  col_q;
  logic signed [31:0]         val_q;

  // row memories
  logic [srpa_pkg::ColW-1:0]  rc_mem [srpa_pkg::MaxCols];
  logic [63:0]                sum_mem [srpa_pkg::MaxCols];
  logic [srpa_pkg::ColW-1:0]  rc_q;
  logic signed [63:0]         sum_q;

  // column map: slot index memory plus flop valid bits
  logic [srpa_pkg::ColW-1:0]  map_mem [srpa_pkg::MaxCols];
  logic [srpa_pkg::ColW-1:0]  map_q;
  logic [srpa_pkg::MaxCols-1:0] map_vld_r, map_vld_nxt;
  logic [srpa_pkg::SlotW-1:0] used_r, used_nxt;

  logic signed [31:0]         aval_r, aval_nxt;
  logic [srpa_pkg::RowW-1:0]  row_r, row_nxt;
  logic [srpa_pkg::PtrW-1:0]  bp_r, bp_nxt, end_r, end_nxt;
  logic [srpa_pkg::ColW-1:0]  col_r, col_nxt;
  logic signed [63:0]         prod_r, prod_nxt;
  logic [srpa_pkg::SlotW-1:0] k_r, k_nxt;

  logic                       out_vld_r, out_vld_nxt;
  logic [srpa_pkg::ColW-1:0]  oc_r, oc_nxt;
  logic signed [63:0]         ov_r, ov_nxt;
  logic                       oe_r, oe_nxt, ol_r, ol_nxt;

  logic                       acc_new;
  logic                       in_xfer;
  logic [srpa_pkg::SlotW-1:0] map_idx;

  assign in_tready = (state_r == srpa_pkg::ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign map_idx   = {1'b0, map_q};

  // read addresses
  logic [srpa_pkg::RowW-1:0]  rs_addr;
  logic [srpa_pkg::AddrW-1:0] ent_addr;
  logic [srpa_pkg::ColW-1:0]  slot_addr;

  always_comb begin
    rs_addr = (state_r == srpa_pkg::ST_RS0) ? row_r : row_r + 1'b1;
  end
  assign ent_addr  = bp_r[srpa_pkg::AddrW-1:0];
  assign slot_addr = k_r[srpa_pkg::ColW-1:0];

  always_ff @(posedge clk) begin
    if (in_xfer && f_op == srpa_pkg::OP_LOAD_START && f_row <= srpa_pkg::BRows) begin
      rs_mem[f_row] <= f_ptr;
    end
    rs_q <= rs_mem[rs_addr];
  end

  always_ff @(posedge clk) begin
    if (in_xfer && f_op == srpa_pkg::OP_LOAD_ENTRY) begin
      col_mem[f_slot] <= f_col;
      val_mem[f_slot] <= f_bval;
    end
    col_q <= col_mem[ent_addr];
    val_q <= val_mem[ent_addr];
  end

  // map memory: written when a new slot is handed out
  always_ff @(posedge clk) begin
    if (state_r == srpa_pkg::ST_MUL && !map_vld_r[col_q] && used_r < srpa_pkg::MaxCols) begin
      map_mem[col_q] <= used_r[srpa_pkg::ColW-1:0];
    end
    map_q <= map_mem[col_q];
  end

  // slot memories: read for accumulate or emit, written on accumulate
  logic [srpa_pkg::ColW-1:0] sum_raddr;
  assign sum_raddr = (state_r == srpa_pkg::ST_EMIT_RD) ? slot_addr : map_q;

  always_ff @(posedge clk) begin
    if (state_r == srpa_pkg::ST_ACC) begin
      sum_mem[k_r[srpa_pkg::ColW-1:0]] <= acc_new ? prod_r
                                                  : srpa_pkg::sat_add(sum_q, prod_r);
      if (acc_new) begin
        rc_mem[k_r[srpa_pkg::ColW-1:0]] <= col_r;
      end
    end
    sum_q <= sum_mem[sum_raddr];
    rc_q  <= rc_mem[slot_addr];
  end

  logic acc_new_r, acc_new_nxt, acc_skip_r, acc_skip_nxt;
  assign acc_new = acc_new_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srpa_pkg::ST_IDLE: begin
        if (in_xfer && f_op == srpa_pkg::OP_A_NONZERO) begin
          state_nxt = (f_row < srpa_pkg::BRows) ? srpa_pkg::ST_RS0 : srpa_pkg::ST_IDLE;
        end else if (in_xfer && f_op == srpa_pkg::OP_END_ROW) begin
          state_nxt = srpa_pkg::ST_EMIT_RD;
        end
      end
      srpa_pkg::ST_RS0:    state_nxt = srpa_pkg::ST_RS1;
      srpa_pkg::ST_RS1:    state_nxt = srpa_pkg::ST_RS2;
      srpa_pkg::ST_RS2:    state_nxt = (bp_r < end_nxt) ? srpa_pkg::ST_RD : srpa_pkg::ST_IDLE;
      srpa_pkg::ST_RD:     state_nxt = srpa_pkg::ST_MUL;
      srpa_pkg::ST_MUL:    state_nxt = srpa_pkg::ST_ACC_RD;
      srpa_pkg::ST_ACC_RD: begin
        // map full and column new: nothing to write, go to the next entry or back to idle
        if (acc_skip_r) begin
          state_nxt = (bp_r < end_r) ? srpa_pkg::ST_RD : srpa_pkg::ST_IDLE;
        end else begin
          state_nxt = srpa_pkg::ST_ACC;
        end
      end
      srpa_pkg::ST_ACC:    state_nxt = (bp_r < end_r) ? srpa_pkg::ST_RD : srpa_pkg::ST_IDLE;
      srpa_pkg::ST_EMIT_RD: begin
        if (!out_vld_r || out_tready) state_nxt = srpa_pkg::ST_EMIT;
      end
      srpa_pkg::ST_EMIT: begin
        if (used_r == '0 || k_r + 1'b1 >= used_r) state_nxt = srpa_pkg::ST_CLEAR;
        else state_nxt = srpa_pkg::ST_EMIT_RD;
      end
      srpa_pkg::ST_CLEAR:  state_nxt = srpa_pkg::ST_IDLE;
      default:             state_nxt = srpa_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    aval_nxt     = aval_r;
    row_nxt      = row_r;
    bp_nxt       = bp_r;
    end_nxt      = end_r;
    col_nxt      = col_r;
    prod_nxt     = prod_r;
    k_nxt        = k_r;
    map_vld_nxt  = map_vld_r;
    used_nxt     = used_r;
    acc_new_nxt  = acc_new_r;
    acc_skip_nxt = acc_skip_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    oc_nxt       = oc_r;
    ov_nxt       = ov_r;
    oe_nxt       = oe_r;
    ol_nxt       = ol_r;
    case (state_r)
      srpa_pkg::ST_IDLE: begin
        if (in_xfer) begin
          aval_nxt = f_aval;
          row_nxt  = f_row;
          k_nxt    = '0;
        end
      end
      srpa_pkg::ST_RS1: bp_nxt = rs_q;
      srpa_pkg::ST_RS2: begin
        end_nxt = (rs_q > srpa_pkg::BEntries) ? srpa_pkg::PtrW'(srpa_pkg::BEntries) : rs_q;
      end
      srpa_pkg::ST_RD: bp_nxt = bp_r + 1'b1;
      srpa_pkg::ST_MUL: begin
        col_nxt  = col_q;
        prod_nxt = aval_r * val_q;
        acc_new_nxt  = !map_vld_r[col_q];
        acc_skip_nxt = !map_vld_r[col_q] && used_r >= srpa_pkg::MaxCols;
        if (!map_vld_r[col_q] && used_r < srpa_pkg::MaxCols) begin
          map_vld_nxt[col_q] = 1'b1;
          k_nxt    = used_r;
          used_nxt = used_r + 1'b1;
        end
      end
      srpa_pkg::ST_ACC_RD: begin
        if (!acc_new_r) k_nxt = map_idx;
      end
      srpa_pkg::ST_EMIT_RD: ;
      srpa_pkg::ST_EMIT: begin
        out_vld_nxt = 1'b1;
        if (used_r == '0) begin
          oc_nxt = '0; ov_nxt = '0; oe_nxt = 1'b0; ol_nxt = 1'b1;
        end else begin
          oc_nxt = rc_q; ov_nxt = sum_q; oe_nxt = 1'b1;
          ol_nxt = (k_r + 1'b1 >= used_r);
          k_nxt  = k_r + 1'b1;
        end
      end
      srpa_pkg::ST_CLEAR: begin
        map_vld_nxt = '0;
        used_nxt    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= srpa_pkg::ST_IDLE;
      map_vld_r <= '0;
      used_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      map_vld_r <= map_vld_nxt;
      used_r    <= used_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    aval_r     <= aval_nxt;
    row_r      <= row_nxt;
    bp_r       <= bp_nxt;
    end_r      <= end_nxt;
    col_r      <= col_nxt;
    prod_r     <= prod_nxt;
    k_r        <= k_nxt;
    acc_new_r  <= acc_new_nxt;
    acc_skip_r <= acc_skip_nxt;
    oc_r       <= oc_nxt;
    ov_r       <= ov_nxt;
    oe_r       <= oe_nxt;
    ol_r       <= ol_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, ov_r, oc_r};
  assign out_tuser  = oe_r;
  assign out_tlast  = ol_r;

  `SRPA_ASSERT(a_used_cap, clk, rst_n, (used_r <= srpa_pkg::MaxCols), "slot count over capacity")
  `SRPA_ASSERT(a_cnt_vld, clk, rst_n, ($countones(map_vld_r) == used_r), "valid count mismatch")
  `SRPA_ASSERT(a_marker, clk, rst_n, (out_tvalid && !out_tuser |-> out_tlast), "marker without last")
  `SRPA_ASSERT_NEXT(a_clear, clk, rst_n, state_r == srpa_pkg::ST_CLEAR, used_r == '0, "map not cleared")

endmodule

@@ test/sparse_row_product_accumulator_top_tb.sv @@
`timescale 1ns / 100ps

module sparse_row_product_accumulator_top_tb;

  typedef struct {
    logic [5:0]  column;
    logic [63:0] value;
    logic        entry_valid;
    logic        row_last;
  } row_entry_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;
  logic         out_tuser;
  logic         out_tlast;

  // shadow copy of the B matrix and the row accumulator
  logic [12:0] row_start_mem [0:srpa_pkg::BRows];
  bit          row_start_set [0:srpa_pkg::BRows];
  logic [5:0]  entry_col_mem [0:srpa_pkg::BEntries-1];
  logic [31:0] entry_val_mem [0:srpa_pkg::BEntries-1];
  bit          entry_set     [0:srpa_pkg::BEntries-1];
  int          col_slot      [0:srpa_pkg::MaxCols-1];
  logic [5:0]  slot_col      [0:srpa_pkg::MaxCols-1];
  logic [63:0] slot_sum      [0:srpa_pkg::MaxCols-1];
  int          slots_taken;

  row_entry_t  pending_entries[$];
  int          error_count;
  bit          quiet_phase;
  int          ready_stall;

  always #4 clk = ~clk;

  sparse_row_product_accumulator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic logic [63:0] add_saturating(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] r;
    r = x + y;
    if (x[63] == y[63] && r[63] != x[63]) return x[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return r;
  endfunction

  // a row walk is legal when the row is past the table, or when both bounds and every entry in range are loaded
  function automatic bit row_walkable(input int row);
    int stop;
    if (row >= srpa_pkg::BRows) return 1'b1;
    if (!row_start_set[row] || !row_start_set[row+1]) return 1'b0;
    stop = (row_start_mem[row+1] > srpa_pkg::BEntries) ? srpa_pkg::BEntries
                                                         : row_start_mem[row+1];
    for (int p = row_start_mem[row]; p < stop; p++)
      if (!entry_set[p]) return 1'b0;
    return 1'b1;
  endfunction

  // golden update for one accepted transfer
  task automatic predict_row_product(input srpa_pkg::opcode_t op, input int row,
                                     input int ptr, input int slot, input logic [5:0] col,
                                     input logic [31:0] bval, input logic [31:0] aval);
    int stop;
    logic [63:0] prod;
    row_entry_t e;
    case (op)
      srpa_pkg::OP_LOAD_START: begin
        if (row <= srpa_pkg::BRows) begin
          row_start_mem[row] = ptr[12:0];
          row_start_set[row] = 1'b1;
        end
      end
      srpa_pkg::OP_LOAD_ENTRY: begin
        entry_col_mem[slot] = col;
        entry_val_mem[slot] = bval;
        entry_set[slot] = 1'b1;
      end
      srpa_pkg::OP_A_NONZERO: begin
        if (row < srpa_pkg::BRows) begin
          stop = (row_start_mem[row+1] > srpa_pkg::BEntries) ? srpa_pkg::BEntries
                                                               : row_start_mem[row+1];
          for (int p = row_start_mem[row]; p < stop; p++) begin
            prod = $signed({{32{aval[31]}}, aval}) *
                   $signed({{32{entry_val_mem[p][31]}}, entry_val_mem[p]});
            if (col_slot[entry_col_mem[p]] < 0) begin
              if (slots_taken < srpa_pkg::MaxCols) begin
                col_slot[entry_col_mem[p]] = slots_taken;
                slot_col[slots_taken] = entry_col_mem[p];
                slot_sum[slots_taken] = prod;
                slots_taken++;
              end
            end else begin
              slot_sum[col_slot[entry_col_mem[p]]] =
                add_saturating(slot_sum[col_slot[entry_col_mem[p]]], prod);
            end
          end
        end
      end
      default: begin
        if (slots_taken == 0) begin
          e = '{6'd0, 64'd0, 1'b0, 1'b1};
          pending_entries.push_back(e);
        end
        for (int k = 0; k < slots_taken; k++) begin
          e = '{slot_col[k], slot_sum[k], 1'b1, k == slots_taken - 1};
          pending_entries.push_back(e);
        end
        foreach (col_slot[c]) col_slot[c] = -1;
        slots_taken = 0;
      end
    endcase
  endtask

  // one input transfer, with an optional idle burst before it
  task automatic send_item(input srpa_pkg::opcode_t op, input int row, input int ptr,
                           input int slot, input logic [5:0] col, input logic [31:0] bval,
                           input logic [31:0] aval);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, aval, bval, col, slot[11:0], ptr[12:0], row[8:0], op};
    do @(posedge clk); while (!in_tready);
    predict_row_product(op, row, ptr, slot, col, bval, aval);
    @(negedge clk);
  endtask

  task automatic load_start(input int row, input int ptr);
    send_item(srpa_pkg::OP_LOAD_START, row, ptr, $urandom_range(0, 4095), 6'($urandom),
              $urandom, $urandom);
  endtask

  task automatic load_entry(input int slot, input logic [5:0] col, input logic [31:0] v);
    send_item(srpa_pkg::OP_LOAD_ENTRY, $urandom_range(0, 511), $urandom_range(0, 8191),
              slot, col, v, $urandom);
  endtask

  task automatic a_nonzero(input int row, input logic [31:0] aval);
    send_item(srpa_pkg::OP_A_NONZERO, row, $urandom_range(0, 8191), $urandom_range(0, 4095),
              6'($urandom), $urandom, aval);
  endtask

  task automatic end_row();
    send_item(srpa_pkg::OP_END_ROW, $urandom_range(0, 511), $urandom_range(0, 8191),
              $urandom_range(0, 4095), 6'($urandom), $urandom, $urandom);
  endtask

  // B layout: rows 0..15 hold four entries each, row 17 spans all of 0..63,
  // row 19 runs up to the top of the entry store, rows 16 and 20..22 are empty walks
  task automatic test_load_b();
    for (int i = 0; i < 64; i++) load_entry(i, i[5:0], $urandom);
    for (int i = 4088; i < 4096; i++) load_entry(i, 6'($urandom), $urandom);
    for (int r = 0; r <= 16; r++) load_start(r, 4 * r);
    load_start(17, 0);
    load_start(18, 64);
    load_start(19, 4090);
    load_start(20, 4096);   // row 19 ends at the store top, row 20 starts there
    load_start(21, 8191);   // row 20 end past the store, clamped
    load_start(22, 30);
    load_start(23, 10);     // start after end: empty walk
    load_start(24, 12);     // row 23 walks entries 10 and 11
    load_start(256, 4096);
    load_start(300, 7);     // index past the table, dropped
  endtask

  task automatic test_directed_rows();
    end_row();                                  // empty row marker
    a_nonzero(17, 32'h8000_0000);               // full 64 slots
    load_entry(1, 6'd1, 32'h8000_0000);
    a_nonzero(0, 32'h8000_0000);                // min*min twice overflows high
    a_nonzero(0, 32'h8000_0000);
    a_nonzero(19, 32'h7FFF_FFFF);
    a_nonzero(20, 32'h0001_0000);
    a_nonzero(23, 32'h0001_0000);
    a_nonzero(300, 32'hFFFF_FFFF);              // row out of range adds nothing
    end_row();
    load_entry(2, 6'd2, 32'h7FFF_FFFF);
    a_nonzero(0, 32'h8000_0000);                // large negative sums saturate low
    a_nonzero(0, 32'h8000_0000);
    a_nonzero(0, 32'h8000_0000);
    end_row();
    end_row();
  endtask

  task automatic test_random_rows();
    int row;
    int sent;
    int pick;
    sent = 0;
    while (sent < 12) begin
      quiet_phase = (sent >= 8);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 9) == 0) row = $urandom_range(256, 511);
        else do row = $urandom_range(0, 23); while (!row_walkable(row));
        a_nonzero(row, ($urandom_range(0, 7) == 0) ? 32'h8000_0000 : $urandom);
      end else if (pick < 80) begin
        end_row();
      end else if (pick < 90) begin
        load_entry(($urandom_range(0, 1) != 0) ? $urandom_range(0, 63) :
                   $urandom_range(4088, 4095), 6'($urandom),
                   ($urandom_range(0, 3) == 0) ? 32'h7FFF_FFFF : $urandom);
      end else begin
        row = $urandom_range(0, 16);
        load_start(row, ($urandom_range(0, 4) == 0) ? 8191 : $urandom_range(0, 64));
      end
      sent++;
    end
    end_row();
    in_tvalid <= 1'b0;
  endtask

  // result sink backpressure
  always @(negedge clk) begin
    if (quiet_phase) begin
      out_tready <= 1'b1;
    end else if (ready_stall > 0) begin
      ready_stall--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      ready_stall = $urandom_range(1, 15) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each result transfer against the oldest expectation
  always @(posedge clk) begin
    row_entry_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_entries.size() == 0) begin
        report($sformatf("unexpected result col %0d", out_tdata[5:0]));
      end else begin
        e = pending_entries.pop_front();
        if (out_tdata[5:0] !== e.column)
          report($sformatf("column %0d, want %0d", out_tdata[5:0], e.column));
        if (out_tdata[69:6] !== e.value)
          report($sformatf("value %h, want %h", out_tdata[69:6], e.value));
        if (out_tdata[71:70] !== 2'b00) report("fill bits not zero");
        if (out_tuser !== e.entry_valid)
          report($sformatf("entry_valid %b, want %b", out_tuser, e.entry_valid));
        if (out_tlast !== e.row_last)
          report($sformatf("row_last %b, want %b", out_tlast, e.row_last));
      end
    end
  end

  initial begin
    #20ms;
    $display("sparse_row_product_accumulator_top_tb NOT OK");
    $finish;
  end

  initial begin
    error_count = 0;
    quiet_phase = 1'b0;
    ready_stall = 0;
    slots_taken = 0;
    foreach (col_slot[c]) col_slot[c] = -1;
    foreach (row_start_set[r]) row_start_set[r] = 1'b0;
    foreach (entry_set[s]) entry_set[s] = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_load_b();
    test_directed_rows();
    test_random_rows();
    while (pending_entries.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (error_count == 0) begin
      $display("sparse_row_product_accumulator_top_tb OK");
    end else begin
      $display("sparse_row_product_accumulator_top_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ sparse_row_product_accumulator_top.f @@
+incdir+rtl
rtl/srpa_pkg.sv
rtl/sparse_row_product_accumulator_top.sv
test/sparse_row_product_accumulator_top_tb.sv
